@@ rtl/core/shbb_pkg.sv @@
// Shared constants and types for the spline hull bounding box block.
package shbb_pkg;

    // Default coordinate width of the point fields
    localparam int COORD_BITS_DEF = 16;

    // Width of the half line width register
    localparam int HALF_WIDTH_BITS = 8;

    // Configuration register index width
    localparam int CFG_INDEX_BITS = 2;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_INTERPOLATED_MODE = 2'd0,
        CFG_CLOSED_CURVE      = 2'd1,
        CFG_HALF_WIDTH        = 2'd2
    } t_cfg_index;

    // Saturating count of points folded into the current spline
    typedef enum logic [1:0] {
        SEEN_NONE = 2'd0,
        SEEN_ONE  = 2'd1,
        SEEN_MANY = 2'd2
    } t_seen;

endpackage

@@ rtl/core/spline_hull_bounding_box.sv @@
// Spline bounding box: folds spline points into quarter-unit bounds, emits the padded box.
//
//  Channel   Direction  Handshake                   Payload
//  input     in         i_valid / o_ready           i_point_*, i_left_ctrl_*, i_right_ctrl_*,
//                                                   i_is_last
//  result    out        o_valid / i_ready           o_box_xmin, o_box_ymin, o_box_xmax, o_box_ymax
//  config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
//  One point per cycle sustained. Three register stages: input register, bounds
//  fold (running state plus a box register for last points), round/pad/saturate
//  into the result register. o_valid rises once a last point has passed from the
//  input register through the box register into the result register.
//  Reset (synchronous, active low) clears valids, config and the running state.
//  A stalled result only holds back points marked last; other points keep flowing
//  as long as the input register can drain.
module spline_hull_bounding_box #(
    parameter int COORD_BITS = shbb_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // point transactions
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [COORD_BITS-1:0]          i_point_x,
    input  logic signed [COORD_BITS-1:0]          i_point_y,
    input  logic signed [COORD_BITS-1:0]          i_left_ctrl_x,
    input  logic signed [COORD_BITS-1:0]          i_left_ctrl_y,
    input  logic signed [COORD_BITS-1:0]          i_right_ctrl_x,
    input  logic signed [COORD_BITS-1:0]          i_right_ctrl_y,
    input  logic                                  i_is_last,
    // box transactions
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [COORD_BITS:0]            o_box_xmin,
    output logic signed [COORD_BITS:0]            o_box_ymin,
    output logic signed [COORD_BITS:0]            o_box_xmax,
    output logic signed [COORD_BITS:0]            o_box_ymax,
    // configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [shbb_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [shbb_pkg::HALF_WIDTH_BITS-1:0]  i_cfg_data
);

    // quarter-unit width and output width
    localparam int Q  = COORD_BITS + 2;
    localparam int OB = COORD_BITS + 1;
    localparam int HB = shbb_pkg::HALF_WIDTH_BITS;
    localparam logic signed [Q-1:0] OUT_MAX = Q'((1 << COORD_BITS) - 1);
    localparam logic signed [Q-1:0] OUT_MIN = -OUT_MAX - Q'(1);

    // round half away from zero to whole units
    function automatic logic signed [Q-1:0] round_q(input logic signed [Q-1:0] q);
        logic          neg;
        logic [Q:0]    mag;
        logic [Q:0]    rnd;
        logic [Q-1:0]  rr;
        neg = q[Q-1];
        mag = neg ? -{q[Q-1], q} : {q[Q-1], q};
        rnd = (mag + (Q+1)'(2)) >> 2;
        rr  = rnd[Q-1:0];
        return neg ? -$signed(rr) : $signed(rr);
    endfunction

    // clamp into the output field
    function automatic logic signed [OB-1:0] sat_out(input logic signed [Q-1:0] v);
        logic signed [Q-1:0] c;
        c = v;
        if (v > OUT_MAX) c = OUT_MAX;
        if (v < OUT_MIN) c = OUT_MIN;
        return c[OB-1:0];
    endfunction

    // configuration registers
    logic          r_interp;
    logic          r_closed;
    logic [HB-1:0] r_half_width;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp     <= 1'b0;
            r_closed     <= 1'b0;
            r_half_width <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                shbb_pkg::CFG_INTERPOLATED_MODE: r_interp     <= i_cfg_data[0];
                shbb_pkg::CFG_CLOSED_CURVE:      r_closed     <= i_cfg_data[0];
                shbb_pkg::CFG_HALF_WIDTH:        r_half_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline handshake
    logic r_in_valid;
    logic r_fin_valid;
    logic r_out_valid;
    logic r_in_last;
    logic out_rdy;
    logic fin_rdy;
    logic cmp_go;

    assign out_rdy = !r_out_valid || i_ready;
    assign fin_rdy = !r_fin_valid || out_rdy;
    assign cmp_go  = r_in_valid && (!r_in_last || fin_rdy);
    assign o_ready = !r_in_valid || cmp_go;
    assign o_valid = r_out_valid;

    // input register, one lane per axis (0 = x, 1 = y)
    logic signed [COORD_BITS-1:0] r_pt [2];
    logic signed [COORD_BITS-1:0] r_lc [2];
    logic signed [COORD_BITS-1:0] r_rc [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pt[0]   <= i_point_x;
            r_pt[1]   <= i_point_y;
            r_lc[0]   <= i_left_ctrl_x;
            r_lc[1]   <= i_left_ctrl_y;
            r_rc[0]   <= i_right_ctrl_x;
            r_rc[1]   <= i_right_ctrl_y;
            r_in_last <= i_is_last;
        end
    end

    // running state
    logic signed [COORD_BITS-1:0] r_prev   [2];
    logic signed [COORD_BITS-1:0] r_prev_r [2];
    logic signed [Q-1:0]          r_min    [2];
    logic signed [Q-1:0]          r_max    [2];
    shbb_pkg::t_seen              r_seen;
    logic signed [Q-1:0]          n_min    [2];
    logic signed [Q-1:0]          n_max    [2];
    shbb_pkg::t_seen              n_seen;

    // fold this point's candidates into the bounds
    always_comb begin
        logic signed [Q-1:0] a, b, c, d;
        logic signed [Q-1:0] cand [8];
        logic [7:0]          en;
        logic signed [Q-1:0] lo, hi;
        logic                first, pair;
        first = (r_seen == shbb_pkg::SEEN_NONE);
        pair  = (r_seen == shbb_pkg::SEEN_ONE);
        for (int k = 0; k < 2; k++) begin
            a = Q'(r_prev[k]);
            b = Q'(r_prev_r[k]);
            c = Q'(r_lc[k]);
            d = Q'(r_pt[k]);
            cand[0] = a <<< 2;
            cand[1] = (a + b) <<< 1;
            cand[2] = a + (b <<< 1) + c;
            cand[3] = b + (c <<< 1) + d;
            cand[4] = (c + d) <<< 1;
            cand[5] = d <<< 2;
            cand[6] = (a <<< 1) + a + d;
            cand[7] = a + (d <<< 1) + d;
            en = '0;
            // base bounds
            if (first) begin
                lo = cand[5];
                hi = cand[5];
            end else if (!r_interp && pair) begin
                lo = r_closed ? cand[6] : cand[0];
                hi = lo;
            end else begin
                lo = r_min[k];
                hi = r_max[k];
            end
            // enabled candidates
            if (!first) begin
                if (r_interp) begin
                    en[5:0] = 6'h3f;
                end else begin
                    en[6] = !pair;
                    en[7] = 1'b1;
                end
            end
            // open approximating curve keeps its last point
            if (r_in_last && !r_interp && !r_closed) begin
                en[5] = 1'b1;
            end
            for (int j = 0; j < 8; j++) begin
                if (en[j] && cand[j] < lo) lo = cand[j];
                if (en[j] && cand[j] > hi) hi = cand[j];
            end
            n_min[k] = lo;
            n_max[k] = hi;
        end
        if (r_in_last) begin
            n_seen = shbb_pkg::SEEN_NONE;
        end else if (first) begin
            n_seen = shbb_pkg::SEEN_ONE;
        end else begin
            n_seen = shbb_pkg::SEEN_MANY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= shbb_pkg::SEEN_NONE;
            for (int k = 0; k < 2; k++) begin
                r_prev[k]   <= '0;
                r_prev_r[k] <= '0;
                r_min[k]    <= '0;
                r_max[k]    <= '0;
            end
        end else if (cmp_go) begin
            r_seen <= n_seen;
            for (int k = 0; k < 2; k++) begin
                r_prev[k]   <= r_pt[k];
                r_prev_r[k] <= r_rc[k];
                r_min[k]    <= n_min[k];
                r_max[k]    <= n_max[k];
            end
        end
    end

    // finished box in quarters
    logic signed [Q-1:0] r_fin_min [2];
    logic signed [Q-1:0] r_fin_max [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else begin
            r_fin_valid <= (r_fin_valid && !out_rdy) || (cmp_go && r_in_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmp_go && r_in_last) begin
            r_fin_min <= n_min;
            r_fin_max <= n_max;
        end
    end

    // round, pad and saturate into the result register
    logic signed [Q-1:0] hw_ext;

    assign hw_ext = $signed(Q'(r_half_width));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_out_valid && !i_ready) || (r_fin_valid && out_rdy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fin_valid && out_rdy) begin
            o_box_xmin <= sat_out(round_q(r_fin_min[0]) - hw_ext);
            o_box_ymin <= sat_out(round_q(r_fin_min[1]) - hw_ext);
            o_box_xmax <= sat_out(round_q(r_fin_max[0]) + hw_ext);
            o_box_ymax <= sat_out(round_q(r_fin_max[1]) + hw_ext);
        end
    end

    // checks
    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_box_xmin <= o_box_xmax) && (o_box_ymin <= o_box_ymax))
        else $error("box minimum above maximum");

    a_fin_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_valid && !out_rdy |=> r_fin_valid && $stable(r_fin_min[0])
            && $stable(r_fin_max[1]))
        else $error("pending box lost while result stalled");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_in_valid && r_in_last && r_fin_valid)
        else $error("input stalled without a pending last point");

endmodule
